// ===== rtl/fatlb_pkg.sv =====
// Shared constants, types and codes for the fully associative TLB.
package fatlb_pkg;

    localparam int ENTRIES    = 16;
    localparam int PAGE_BITS  = 20;
    localparam int FRAME_BITS = 20;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int COUNT_W    = 32;
    localparam int OP_W       = 2;

    // Stream widths: payload packed from bit 0, padded to whole bytes
    localparam int S_DATA_W = ((PAGE_BITS + FRAME_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((FRAME_BITS + 2 * COUNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_FLUSH  = 2'd2
    } fatlb_op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } fatlb_cmd_t;

endpackage

// ===== rtl/fatlb_ctrl.sv =====
// Controller state machine: capture an item, execute it, manage the output register valid.
module fatlb_ctrl
    import fatlb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output fatlb_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   exec_go;

    // Execute once the output register is free or being drained
    assign exec_go     = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.execute = exec_go;

    // Next state and output valid
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/fatlb_dp.sv =====
// Datapath: entry stores, tag compare, LRU ranks, counters and result register.
module fatlb_dp
    import fatlb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fatlb_cmd_t            cmd,
    input  logic [OP_W-1:0]       in_opcode,
    input  logic [PAGE_BITS-1:0]  in_page,
    input  logic [FRAME_BITS-1:0] in_frame,
    output logic                  out_hit,
    output logic [FRAME_BITS-1:0] out_frame,
    output logic [COUNT_W-1:0]    out_hit_count,
    output logic [COUNT_W-1:0]    out_miss_count
);

    localparam logic [IDX_W-1:0]   TOP_RANK  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Captured item
    fatlb_op_t             op_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_in_reg;

    // Entry state
    logic [PAGE_BITS-1:0]  tag_reg   [ENTRIES];
    logic [FRAME_BITS-1:0] frame_reg [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]      rank_reg  [ENTRIES];
    logic [IDX_W-1:0]      rank_next [ENTRIES];
    logic [COUNT_W-1:0]    hits_reg, hits_next;
    logic [COUNT_W-1:0]    misses_reg, misses_next;

    // Result register
    logic                  hit_out_reg, hit_out_next;
    logic [FRAME_BITS-1:0] frame_out_reg, frame_out_next;

    // Match and victim search
    logic                  hit_any, inv_any;
    logic [IDX_W-1:0]      hit_idx, inv_idx, lru_idx, victim_idx, touch_idx;
    logic [IDX_W-1:0]      old_rank;
    logic                  touch;
    logic                  do_insert;

    // Compare all entries; lowest index wins
    always_comb begin
        hit_any = 1'b0;
        inv_any = 1'b0;
        hit_idx = '0;
        inv_idx = '0;
        lru_idx = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (valid_reg[k] && (tag_reg[k] == page_reg)) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(k);
            end
            if (!valid_reg[k]) begin
                inv_any = 1'b1;
                inv_idx = IDX_W'(k);
            end
            if (rank_reg[k] == '0) begin
                lru_idx = IDX_W'(k);
            end
        end
    end

    // Pick the touched entry and update the recency order
    always_comb begin
        victim_idx = inv_any ? inv_idx : lru_idx;
        do_insert  = (op_reg == OP_INSERT);
        touch      = ((op_reg == OP_LOOKUP) && hit_any) || do_insert;
        touch_idx  = do_insert ? victim_idx : hit_idx;
        old_rank   = rank_reg[touch_idx];
        for (int k = 0; k < ENTRIES; k++) begin
            rank_next[k] = rank_reg[k];
            if (touch) begin
                if (IDX_W'(k) == touch_idx) begin
                    rank_next[k] = TOP_RANK;
                end else if (rank_reg[k] > old_rank) begin
                    rank_next[k] = rank_reg[k] - 1'b1;
                end
            end
        end
    end

    // Valid bits, counters and result
    always_comb begin
        valid_next     = valid_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        hit_out_next   = 1'b0;
        frame_out_next = '0;
        unique case (op_reg)
            OP_LOOKUP: begin
                if (hit_any) begin
                    hit_out_next   = 1'b1;
                    frame_out_next = frame_reg[hit_idx];
                    if (hits_reg != COUNT_MAX) begin
                        hits_next = hits_reg + 1'b1;
                    end
                end else if (misses_reg != COUNT_MAX) begin
                    misses_next = misses_reg + 1'b1;
                end
            end
            OP_INSERT: begin
                valid_next[victim_idx] = 1'b1;
            end
            OP_FLUSH: begin
                valid_next  = '0;
                hits_next   = '0;
                misses_next = '0;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Capture the item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= fatlb_op_t'(in_opcode);
            page_reg     <= in_page;
            frame_in_reg <= in_frame;
        end
    end

    // Write tag and frame of the inserted entry
    always_ff @(posedge aclk) begin
        if (cmd.execute && do_insert) begin
            tag_reg[victim_idx]   <= page_reg;
            frame_reg[victim_idx] <= frame_in_reg;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            hit_out_reg   <= hit_out_next;
            frame_out_reg <= frame_out_next;
        end
    end

    // Control state: valid bits, ranks, counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            for (int k = 0; k < ENTRIES; k++) begin
                rank_reg[k] <= IDX_W'(k);
            end
        end else if (cmd.execute) begin
            valid_reg  <= valid_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            for (int k = 0; k < ENTRIES; k++) begin
                rank_reg[k] <= rank_next[k];
            end
        end
    end

    // Counters change only together with the result register
    assign out_hit        = hit_out_reg;
    assign out_frame      = frame_out_reg;
    assign out_hit_count  = hits_reg;
    assign out_miss_count = misses_reg;

endmodule

// ===== rtl/fully_associative_tlb_lru_top.sv =====
// Top level of the fully associative TLB with LRU replacement.
// Each item (lookup, insert or flush) passes through the controller's ST_IDLE
// state, which captures it, and ST_EXEC, which searches all entries, updates
// the recency ranks and counters, and loads the result register; a new item
// is accepted only after the previous one has executed. The result
// register lets the next item be captured while a result still waits on
// m_tready; execution of that item waits until the result is taken.
// s_tuser carries the opcode, s_tdata the page and frame; m_tuser carries
// the hit flag, m_tdata the frame and both saturating counts.
module fully_associative_tlb_lru_top
    import fatlb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // page, frame_in
    input  logic [OP_W-1:0]     s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // frame_out, hit_count, miss_count, zero pad
    output logic [0:0]          m_tuser    // hit
);

    localparam int M_PAD = M_DATA_W - FRAME_BITS - 2 * COUNT_W;

    fatlb_cmd_t            cmd;
    logic                  out_hit;
    logic [FRAME_BITS-1:0] out_frame;
    logic [COUNT_W-1:0]    out_hit_count;
    logic [COUNT_W-1:0]    out_miss_count;

    fatlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fatlb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_opcode      (s_tuser),
        .in_page        (s_tdata[PAGE_BITS-1:0]),
        .in_frame       (s_tdata[PAGE_BITS+FRAME_BITS-1:PAGE_BITS]),
        .out_hit        (out_hit),
        .out_frame      (out_frame),
        .out_hit_count  (out_hit_count),
        .out_miss_count (out_miss_count)
    );

    // Pack the result item
    assign m_tdata    = {{M_PAD{1'b0}}, out_miss_count, out_hit_count, out_frame};
    assign m_tuser[0] = out_hit;

endmodule

// ===== rtl/fatlb_checker.sv =====
// Port-level checker for the TLB top level, with its bind statement.
module fatlb_port_checker
    import fatlb_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [OP_W-1:0]     s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss or non-lookup reports frame zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[FRAME_BITS-1:0] == '0)
        else $error("frame nonzero without hit");

    // A hit is always counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[FRAME_BITS+COUNT_W-1:FRAME_BITS] != '0)
        else $error("hit reported with zero hit count");

    // One item at a time: no accept in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one executes");

endmodule

bind fully_associative_tlb_lru_top fatlb_port_checker u_fatlb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
